FILE: rtl/core/dral_pkg.sv
// Package for the delta-rule associative learner: widths, codes, the
// sequencer state type and the control bundle shared by the core modules.
// Depends on nothing.
package dral_pkg;

  // Number of cues is fixed by the per-cue ports of the top level.
  localparam int NUM_CUES  = 4;
  localparam int IDX_W     = (NUM_CUES > 1) ? $clog2(NUM_CUES) : 1;

  // Field widths.
  localparam int CTRL_W    = 2;
  localparam int W_W       = 32;               // weights, target, prediction
  localparam int ACT_W     = 16;               // activations, Q3.12
  localparam int LR_W      = 16;               // learning rate, Q0.16
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 32;

  // Internal arithmetic widths.
  localparam int ERR_W     = W_W + 1;          // target - prediction
  localparam int STEP_W    = W_W + 2;          // rounded rate * error
  localparam int MUL_A_W   = STEP_W;           // wide multiplier operand
  localparam int MUL_B_W   = ACT_W + 1;        // narrow multiplier operand
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int ACC_W     = W_W + ACT_W + IDX_W;
  localparam int INC_W     = 38;               // rounded step * activation
  localparam int SUM_W     = INC_W + 1;        // weight + increment

  // Rounding shifts.
  localparam int PRED_SH   = 12;
  localparam int STEP_SH   = 16;
  localparam int INC_SH    = 12;

  // Trial control codes.
  localparam logic [CTRL_W-1:0] CTRL_LEARN  = 2'd0;
  localparam logic [CTRL_W-1:0] CTRL_RELOAD = 2'd1;
  localparam logic [CTRL_W-1:0] CTRL_FROZEN = 2'd2;
  localparam int                CTRL_FREEZE_BIT = 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_LEARN_RATE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_W0    = 3'd1;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PRED,
    ST_PDRAIN,
    ST_RND,
    ST_ERR,
    ST_STEP,
    ST_STEPR,
    ST_UPD,
    ST_UDRAIN,
    ST_OUT
  } dral_state_t;

  // Operand selection for the shared multiplier.
  typedef enum logic [1:0] {
    MUL_PRED,
    MUL_STEP,
    MUL_UPD
  } dral_mul_sel_t;

  // Control bundle from the sequencer to the datapath.
  typedef struct packed {
    logic             start;
    logic             reload;
    dral_mul_sel_t    mul_sel;
    logic [IDX_W-1:0] mul_idx;
    logic             acc_en;
    logic             rnd_en;
    logic             err_en;
    logic             step_en;
    logic             inc_en;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic             out_load;
  } dral_ctl_t;

endpackage

FILE: rtl/core/dral_mul.sv
// Shared signed multiplier with a registered product.
// Depends on dral_pkg.
module dral_mul (
  input  logic                                clk,
  input  logic signed [dral_pkg::MUL_A_W-1:0] op_a,
  input  logic signed [dral_pkg::MUL_B_W-1:0] op_b,
  output logic signed [dral_pkg::PROD_W-1:0]  prod_r
);
  import dral_pkg::*;

  logic signed [PROD_W-1:0] prod_nxt;

  // One full product per cycle.
  assign prod_nxt = op_a * op_b;

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

FILE: rtl/core/dral_ctrl.sv
// Sequencer of the learner: walks a trial through prediction, error, step
// and weight update on the shared multiplier. Depends on dral_pkg.
module dral_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [dral_pkg::CTRL_W-1:0]   in_trial_control,
  input  logic                          out_stall,
  output logic                          in_stall,
  output logic                          out_valid,
  output dral_pkg::dral_ctl_t           ctl
);
  import dral_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_CUES - 1);

  dral_state_t      state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             frozen_r, frozen_nxt;
  logic             p1_valid_r, p1_valid_nxt;
  logic [IDX_W-1:0] p1_idx_r, p1_idx_nxt;
  logic             p2_valid_r, p2_valid_nxt;
  logic [IDX_W-1:0] p2_idx_r, p2_idx_nxt;
  logic             out_valid_r, out_valid_nxt;

  // State and pipeline tag registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      frozen_r    <= 1'b0;
      p1_valid_r  <= 1'b0;
      p1_idx_r    <= '0;
      p2_valid_r  <= 1'b0;
      p2_idx_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      frozen_r    <= frozen_nxt;
      p1_valid_r  <= p1_valid_nxt;
      p1_idx_r    <= p1_idx_nxt;
      p2_valid_r  <= p2_valid_nxt;
      p2_idx_r    <= p2_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and control outputs.
  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    frozen_nxt = frozen_r;
    ctl        = '0;
    ctl.mul_sel = MUL_PRED;
    ctl.mul_idx = idx_r;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          ctl.start  = 1'b1;
          ctl.reload = (in_trial_control == CTRL_RELOAD);
          frozen_nxt = in_trial_control[CTRL_FREEZE_BIT];
          idx_nxt    = '0;
          state_nxt  = ST_PRED;
        end
      end
      ST_PRED: begin
        ctl.mul_sel = MUL_PRED;
        if (idx_r == LAST_IDX) begin
          idx_nxt   = '0;
          state_nxt = ST_PDRAIN;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      ST_PDRAIN: state_nxt = ST_RND;
      ST_RND: begin
        ctl.rnd_en = 1'b1;
        state_nxt  = ST_ERR;
      end
      ST_ERR: begin
        ctl.err_en = 1'b1;
        state_nxt  = frozen_r ? ST_OUT : ST_STEP;
      end
      ST_STEP: begin
        ctl.mul_sel = MUL_STEP;
        state_nxt   = ST_STEPR;
      end
      ST_STEPR: begin
        ctl.step_en = 1'b1;
        idx_nxt     = '0;
        state_nxt   = ST_UPD;
      end
      ST_UPD: begin
        ctl.mul_sel = MUL_UPD;
        if (idx_r == LAST_IDX) begin
          idx_nxt   = '0;
          state_nxt = ST_UDRAIN;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      ST_UDRAIN: begin
        if (!p1_valid_r && !p2_valid_r) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          ctl.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    // Products of the prediction pass accumulate in the cycle after issue.
    ctl.acc_en = p1_valid_r && (state_r inside {ST_PRED, ST_PDRAIN});
    // Products of the update pass are rounded, then added to the weight.
    ctl.inc_en = p1_valid_r && (state_r inside {ST_UPD, ST_UDRAIN});
    ctl.wr_en  = p2_valid_r;
    ctl.wr_idx = p2_idx_r;
  end

  // Tags that follow each product down the product pipeline.
  always_comb begin
    p1_valid_nxt = (state_r == ST_PRED) || (state_r == ST_UPD);
    p1_idx_nxt   = idx_r;
    p2_valid_nxt = ctl.inc_en;
    p2_idx_nxt   = p1_idx_r;
  end

  // Result beat is held until taken.
  always_comb begin
    if (ctl.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

FILE: rtl/core/delta_rule_associative_learner_unit.sv
// Top level of the delta-rule associative learner: configuration registers,
// cue weights, trial datapath and result register.
// Depends on dral_pkg, dral_mul and dral_ctrl.
//
//   Channel  Direction  Handshake             Beat contents
//   in_      input      in_valid / in_stall   trial control, target, cue activations
//   out_     output     out_valid / out_stall prediction, new cue weights
//   cfg_     input      cfg_valid / cfg_ready register index and write data
//
// A learning trial keeps the block busy through prediction, error, step
// and weight update, a frozen trial through prediction and error only;
// every product goes through the one shared multiplier, one per cycle.
// Reset (rst_n low, synchronous) clears weights, configuration registers and control.
// A result beat waits in the output register under out_stall; a new trial
// is taken meanwhile, and its result waits until the register is free.
// Configuration writes are always taken (cfg_ready is tied high).
module delta_rule_associative_learner_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  // Trial input
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [dral_pkg::CTRL_W-1:0]         in_trial_control,
  input  logic signed [dral_pkg::W_W-1:0]     in_target_strength,
  input  logic signed [dral_pkg::ACT_W-1:0]   in_cue_act_0,
  input  logic signed [dral_pkg::ACT_W-1:0]   in_cue_act_1,
  input  logic signed [dral_pkg::ACT_W-1:0]   in_cue_act_2,
  input  logic signed [dral_pkg::ACT_W-1:0]   in_cue_act_3,
  // Result output
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [dral_pkg::W_W-1:0]     out_prediction,
  output logic signed [dral_pkg::W_W-1:0]     out_new_weight_0,
  output logic signed [dral_pkg::W_W-1:0]     out_new_weight_1,
  output logic signed [dral_pkg::W_W-1:0]     out_new_weight_2,
  output logic signed [dral_pkg::W_W-1:0]     out_new_weight_3,
  // Configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dral_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dral_pkg::CFG_DAT_W-1:0]      cfg_data
);
  import dral_pkg::*;

  localparam logic signed [ACC_W-1:0]  PRED_HALF = ACC_W'(1) << (PRED_SH - 1);
  localparam logic signed [PROD_W-1:0] STEP_HALF = PROD_W'(1) << (STEP_SH - 1);
  localparam logic signed [PROD_W-1:0] INC_HALF  = PROD_W'(1) << (INC_SH - 1);
  localparam logic signed [W_W-1:0]    W_MAX     = {1'b0, {(W_W-1){1'b1}}};
  localparam logic signed [W_W-1:0]    W_MIN     = {1'b1, {(W_W-1){1'b0}}};

  dral_ctl_t ctl;

  logic [LR_W-1:0]          lr_r;
  logic signed [W_W-1:0]    init_w_r [NUM_CUES];
  logic signed [W_W-1:0]    w_r      [NUM_CUES];
  logic signed [W_W-1:0]    target_r;
  logic signed [ACT_W-1:0]  act_r    [NUM_CUES];
  logic signed [ACT_W-1:0]  in_act   [NUM_CUES];
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [W_W-1:0]    pred_r;
  logic signed [ERR_W-1:0]  err_r;
  logic signed [STEP_W-1:0] step_r;
  logic signed [INC_W-1:0]  inc_r;
  logic signed [W_W-1:0]    out_pred_r;
  logic signed [W_W-1:0]    out_w_r  [NUM_CUES];

  logic signed [MUL_A_W-1:0] op_a;
  logic signed [MUL_B_W-1:0] op_b;
  logic signed [PROD_W-1:0]  prod_r;

  logic signed [ACC_W-1:0]  acc_rnd;
  logic signed [W_W-1:0]    pred_nxt;
  logic signed [ERR_W-1:0]  err_nxt;
  logic signed [PROD_W-1:0] step_rnd;
  logic signed [PROD_W-1:0] inc_rnd;
  logic signed [SUM_W-1:0]  w_sum;
  logic signed [W_W-1:0]    w_upd;
  logic                     cfg_we;

  assign in_act[0] = in_cue_act_0;
  assign in_act[1] = in_cue_act_1;
  assign in_act[2] = in_cue_act_2;
  assign in_act[3] = in_cue_act_3;

  // Sequencer.
  dral_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_trial_control (in_trial_control),
    .out_stall        (out_stall),
    .in_stall         (in_stall),
    .out_valid        (out_valid),
    .ctl              (ctl)
  );

  // Operand selection for the shared multiplier.
  always_comb begin
    case (ctl.mul_sel)
      MUL_STEP: begin
        op_a = {{(MUL_A_W-ERR_W){err_r[ERR_W-1]}}, err_r};
        op_b = {1'b0, lr_r};
      end
      MUL_UPD: begin
        op_a = step_r;
        op_b = {act_r[ctl.mul_idx][ACT_W-1], act_r[ctl.mul_idx]};
      end
      default: begin
        op_a = {{(MUL_A_W-W_W){w_r[ctl.mul_idx][W_W-1]}}, w_r[ctl.mul_idx]};
        op_b = {act_r[ctl.mul_idx][ACT_W-1], act_r[ctl.mul_idx]};
      end
    endcase
  end

  dral_mul u_mul (
    .clk    (clk),
    .op_a   (op_a),
    .op_b   (op_b),
    .prod_r (prod_r)
  );

  // Configuration registers; indexes past the last weight are dropped.
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lr_r <= '0;
      for (int k = 0; k < NUM_CUES; k++) begin
        init_w_r[k] <= '0;
      end
    end else if (cfg_we) begin
      if (cfg_index == REG_LEARN_RATE) begin
        lr_r <= cfg_data[LR_W-1:0];
      end
      for (int k = 0; k < NUM_CUES; k++) begin
        if (cfg_index == REG_INIT_W0 + CFG_IDX_W'(k)) begin
          init_w_r[k] <= cfg_data[W_W-1:0];
        end
      end
    end
  end

  // Round the exact sum to Q15.16 and saturate it.
  always_comb begin
    acc_rnd = acc_r + PRED_HALF;
    if (acc_rnd[ACC_W-1:W_W+PRED_SH-1] == '0 ||
        acc_rnd[ACC_W-1:W_W+PRED_SH-1] == '1) begin
      pred_nxt = acc_rnd[W_W+PRED_SH-1:PRED_SH];
    end else begin
      pred_nxt = acc_rnd[ACC_W-1] ? W_MIN : W_MAX;
    end
  end

  assign err_nxt  = {target_r[W_W-1], target_r} - {pred_r[W_W-1], pred_r};
  assign step_rnd = prod_r + STEP_HALF;
  assign inc_rnd  = prod_r + INC_HALF;

  // Weight plus increment, saturated.
  always_comb begin
    w_sum = {{(SUM_W-W_W){w_r[ctl.wr_idx][W_W-1]}}, w_r[ctl.wr_idx]}
          + {inc_r[INC_W-1], inc_r};
    if (w_sum[SUM_W-1:W_W-1] == '0 || w_sum[SUM_W-1:W_W-1] == '1) begin
      w_upd = w_sum[W_W-1:0];
    end else begin
      w_upd = w_sum[SUM_W-1] ? W_MIN : W_MAX;
    end
  end

  // Cue weights: reload on a reload trial, one write per updated cue.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_CUES; k++) begin
        w_r[k] <= '0;
      end
    end else if (ctl.reload) begin
      for (int k = 0; k < NUM_CUES; k++) begin
        w_r[k] <= init_w_r[k];
      end
    end else if (ctl.wr_en) begin
      w_r[ctl.wr_idx] <= w_upd;
    end
  end

  // Trial datapath registers.
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      target_r <= in_target_strength;
      for (int k = 0; k < NUM_CUES; k++) begin
        act_r[k] <= in_act[k];
      end
      acc_r <= '0;
    end else if (ctl.acc_en) begin
      acc_r <= acc_r + prod_r[ACC_W-1:0];
    end
    if (ctl.rnd_en) begin
      pred_r <= pred_nxt;
    end
    if (ctl.err_en) begin
      err_r <= err_nxt;
    end
    if (ctl.step_en) begin
      step_r <= step_rnd[STEP_SH+STEP_W-1:STEP_SH];
    end
    if (ctl.inc_en) begin
      inc_r <= inc_rnd[INC_SH+INC_W-1:INC_SH];
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_pred_r <= pred_r;
      for (int k = 0; k < NUM_CUES; k++) begin
        out_w_r[k] <= w_r[k];
      end
    end
  end

  assign out_prediction   = out_pred_r;
  assign out_new_weight_0 = out_w_r[0];
  assign out_new_weight_1 = out_w_r[1];
  assign out_new_weight_2 = out_w_r[2];
  assign out_new_weight_3 = out_w_r[3];

endmodule

FILE: rtl/core/dral_checker.sv
// Port-level checker for the delta-rule associative learner, bound to the
// top level. Depends on dral_pkg and delta_rule_associative_learner_unit.
module dral_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic signed [dral_pkg::W_W-1:0]     out_prediction,
  input  logic signed [dral_pkg::W_W-1:0]     out_new_weight_0,
  input  logic signed [dral_pkg::W_W-1:0]     out_new_weight_1,
  input  logic signed [dral_pkg::W_W-1:0]     out_new_weight_2,
  input  logic signed [dral_pkg::W_W-1:0]     out_new_weight_3
);
  import dral_pkg::*;

  // The block comes out of reset ready for a trial.
  a_ready_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> !in_stall)
    else $error("input stalled right after reset");

  // An accepted trial keeps the block busy after it is taken.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall ##1 in_stall)
    else $error("trial input taken again too early");

  // A new result beat only appears at the end of a busy trial.
  a_result_from_trial: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result beat without a trial in progress");

  // A stalled result beat holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_prediction)
      && $stable(out_new_weight_0) && $stable(out_new_weight_1)
      && $stable(out_new_weight_2) && $stable(out_new_weight_3))
    else $error("stalled result beat changed");

endmodule

bind delta_rule_associative_learner_unit dral_checker u_dral_checker (.*);
